// ===== rtl/sid_pkg.sv =====
// Shared types and constants of the slice intensity destriper.
// Used by every module of the block but sid_ram and sid_checker; depends on nothing.
package sid_pkg;

  localparam int MAX_SLICES_DEF = 256;
  localparam int HALF_TAPS      = 7;
  localparam int SAMPLE_W       = 16;
  localparam int SLIDX_W        = 8;
  localparam int NUSE_W         = 9;
  localparam int TAP_W          = 16;
  localparam int CNT_LOG2       = 20;
  localparam int SUM_W          = 36;
  localparam int CNT_W          = 21;
  localparam int FACT_W         = 32;
  localparam int ACC_W          = 40;
  localparam int WSUM_W         = 20;
  localparam int DEN_W          = 37;
  localparam int DIVN_W         = 56;
  localparam int DIVD_W         = 36;
  localparam int Q_W            = 32;
  localparam int DIV_STEPS      = 56;
  localparam int QDEPTH         = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_FIRST = 3'd1;

  localparam logic [FACT_W-1:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [FACT_W-1:0] FACT_POSMAX = 32'h7FFF_FFFF;
  localparam logic [FACT_W-1:0] FACT_NEGMAX = 32'h8000_0000;

  localparam logic [NUSE_W-1:0] SLICES_RST = 9'd256;
  localparam logic [TAP_W-1:0]  TAP_C_RST  = 16'hFFFF;

  typedef struct packed {
    logic [NUSE_W-1:0]                 slices_in_use;
    logic [HALF_TAPS-1:0][TAP_W-1:0]   taps;
  } cfg_t;

  typedef struct packed {
    logic                       req_type;
    logic [SLIDX_W-1:0]         slice;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       present;
    logic                       last;
    logic                       in_use;
  } item_t;

endpackage

// ===== rtl/sid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sid_front.sv =====
// Input side: takes stream words, marks whether the slice is in use and
// queues them for the back end. Depends on sid_pkg.
module sid_front #(
  parameter int MAX_SLICES = sid_pkg::MAX_SLICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  input  logic [sid_pkg::NUSE_W-1:0]    slices_in_use,
  input  logic                          clearing,
  input  logic                          pop,
  output sid_pkg::item_t                head,
  output logic                          head_valid
);

  localparam int PW = $clog2(sid_pkg::QDEPTH);

  sid_pkg::item_t        q [sid_pkg::QDEPTH];
  logic [PW-1:0]         wptr;
  logic [PW-1:0]         rptr;
  logic [PW:0]           fill;
  sid_pkg::item_t        incoming;
  logic                  push;
  logic                  do_pop;

  always_comb begin
    incoming.req_type = s_axis_tuser[0];
    incoming.present  = s_axis_tuser[1];
    incoming.slice    = s_axis_tdata[7:0];
    incoming.sample   = s_axis_tdata[23:8];
    incoming.last     = s_axis_tlast;
    incoming.in_use   = ({1'b0, s_axis_tdata[7:0]} < slices_in_use) &&
                        (32'(s_axis_tdata[7:0]) < MAX_SLICES);
  end

  assign s_axis_tready = (fill != (PW+1)'(sid_pkg::QDEPTH)) && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid    = (fill != '0);
  assign do_pop        = pop && head_valid;
  assign head          = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= incoming;
    end
  end

endmodule

// ===== rtl/sid_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, with an overflow
// flag for quotients past 32 bits. Depends on sid_pkg.
module sid_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sid_pkg::DIVN_W-1:0]  num,
  input  logic [sid_pkg::DIVD_W-1:0]  den,
  output logic                        done,
  output logic [sid_pkg::Q_W-1:0]     quot,
  output logic                        ovf
);

  localparam int CW = $clog2(sid_pkg::DIV_STEPS);

  logic [sid_pkg::DIVN_W-1:0] nreg;
  logic [sid_pkg::DIVD_W-1:0] dreg;
  logic [sid_pkg::DIVD_W-1:0] rem;
  logic [sid_pkg::DIVD_W:0]   shifted;
  logic                       qbit;
  logic [sid_pkg::DIVD_W-1:0] rem_next;
  logic [CW-1:0]              cnt;
  logic                       busy;

  always_comb begin
    shifted  = {rem, nreg[sid_pkg::DIVN_W-1]};
    qbit     = shifted >= {1'b0, dreg};
    rem_next = qbit ? sid_pkg::DIVD_W'(shifted - {1'b0, dreg})
                    : shifted[sid_pkg::DIVD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(sid_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
      dreg <= den;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      nreg <= {nreg[sid_pkg::DIVN_W-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[sid_pkg::Q_W-2:0], qbit};
      ovf  <= ovf | quot[sid_pkg::Q_W-1];
    end
  end

endmodule

// ===== rtl/sid_back.sv =====
// Back end: per-slice accumulation, the end-of-pass walk (means, smoothing,
// factors) and voxel correction. Depends on sid_pkg, sid_ram and sid_div.
module sid_back #(
  parameter int MAX_SLICES = sid_pkg::MAX_SLICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sid_pkg::cfg_t                  cfg,
  input  sid_pkg::item_t                 head,
  input  logic                           head_valid,
  output logic                           pop,
  output logic                           clearing,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sid_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                           out_present,
  output logic                           out_last
);

  localparam int AW = $clog2(MAX_SLICES);
  localparam int NB = $clog2(MAX_SLICES + 1);
  localparam int IW = ((NB > sid_pkg::NUSE_W) ? NB : sid_pkg::NUSE_W) + 1;
  localparam int TW = $clog2(sid_pkg::HALF_TAPS);
  localparam int SW = sid_pkg::SAMPLE_W;

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_MEAS   = 14'b00000000000100,
    ST_CMUL   = 14'b00000000001000,
    ST_CSAT   = 14'b00000000010000,
    ST_W1_ISS = 14'b00000000100000,
    ST_W1_LD  = 14'b00000001000000,
    ST_W1_DIV = 14'b00000010000000,
    ST_S_ISS  = 14'b00000100000000,
    ST_S_MUL  = 14'b00001000000000,
    ST_S_ACC  = 14'b00010000000000,
    ST_S_DEN  = 14'b00100000000000,
    ST_S_DLD  = 14'b01000000000000,
    ST_S_DIV  = 14'b10000000000000
  } state_t;

  state_t                              state;
  sid_pkg::item_t                      cur;
  logic [AW-1:0]                       clr_idx;
  logic [AW-1:0]                       s;
  logic [TW-1:0]                       tap_o;
  logic                                tap_hi;
  logic signed [sid_pkg::ACC_W-1:0]    acc;
  logic [sid_pkg::WSUM_W-1:0]          wsum;
  logic signed [SW-1:0]                mean_c;
  logic signed [32:0]                  sprod;
  logic signed [47:0]                  cprod;
  logic signed [sid_pkg::DEN_W-1:0]    den;
  logic                                neg;

  // RAM ports
  logic                                sc_we;
  logic [AW-1:0]                       sc_waddr;
  logic [AW-1:0]                       sc_raddr;
  logic [sid_pkg::SUM_W-1:0]           sum_wd;
  logic signed [sid_pkg::SUM_W-1:0]    sum_rd;
  logic [sid_pkg::CNT_W-1:0]           cnt_wd;
  logic [sid_pkg::CNT_W-1:0]           cnt_rd;
  logic                                mean_we;
  logic [SW-1:0]                       mean_wd;
  logic signed [SW-1:0]                mean_rd;
  logic [AW-1:0]                       mean_raddr;
  logic                                fact_we;
  logic [sid_pkg::FACT_W-1:0]          fact_wd;
  logic signed [sid_pkg::FACT_W-1:0]   fact_rd;

  // divider
  logic                                div_start;
  logic [sid_pkg::DIVN_W-1:0]          div_num;
  logic [sid_pkg::DIVD_W-1:0]          div_den;
  logic                                div_done;
  logic [sid_pkg::Q_W-1:0]             div_q;
  logic                                div_ovf;

  logic [IW-1:0]                       n_eff;
  logic                                last_slice;
  logic [IW-1:0]                       nb_idx;
  logic                                nb_ok;
  logic                                last_tap;
  logic [sid_pkg::TAP_W-1:0]           tap_w;
  logic [sid_pkg::SUM_W-1:0]           sum_mag;
  logic [sid_pkg::ACC_W-1:0]           acc_mag;
  logic [sid_pkg::DEN_W-1:0]           den_mag;
  logic [47:0]                         pmag;
  logic [31:0]                         pshift;
  logic [SW-1:0]                       sat_val;
  logic                                meas_upd;
  logic [sid_pkg::FACT_W-1:0]          fact_div;
  logic                                out_free;

  always_comb begin
    n_eff = (IW'(cfg.slices_in_use) > IW'(MAX_SLICES)) ? IW'(MAX_SLICES)
                                                       : IW'(cfg.slices_in_use);
    last_slice = (IW'(s) == n_eff - 1'b1);
    last_tap   = tap_hi && (tap_o == TW'(sid_pkg::HALF_TAPS - 1));
    tap_w      = cfg.taps[tap_o];
    if (tap_hi) begin
      nb_idx = IW'(s) + IW'(tap_o);
      nb_ok  = nb_idx < n_eff;
    end else begin
      nb_idx = IW'(s) - IW'(tap_o);
      nb_ok  = IW'(s) >= IW'(tap_o);
    end
    mean_raddr = AW'(nb_idx);
    sum_mag = sum_rd[sid_pkg::SUM_W-1] ? sid_pkg::SUM_W'(-sum_rd) : sid_pkg::SUM_W'(sum_rd);
    acc_mag = acc[sid_pkg::ACC_W-1] ? sid_pkg::ACC_W'(-acc) : sid_pkg::ACC_W'(acc);
    den_mag = den[sid_pkg::DEN_W-1] ? sid_pkg::DEN_W'(-den) : sid_pkg::DEN_W'(den);
    pmag    = cprod[47] ? 48'(-cprod) : 48'(cprod);
    pshift  = pmag[47:16];
    if (cprod[47]) begin
      sat_val = (pshift > 32'd32768) ? {1'b1, {(SW-1){1'b0}}} : SW'(-pshift[SW-1:0]);
    end else begin
      sat_val = (pshift > 32'd32767) ? {1'b0, {(SW-1){1'b1}}} : pshift[SW-1:0];
    end
    if (div_ovf || div_q[sid_pkg::Q_W-1]) begin
      fact_div = neg ? sid_pkg::FACT_NEGMAX : sid_pkg::FACT_POSMAX;
    end else begin
      fact_div = neg ? sid_pkg::FACT_W'(-div_q) : div_q;
    end
    meas_upd = cur.present && cur.in_use &&
               (cnt_rd < sid_pkg::CNT_W'(1 << sid_pkg::CNT_LOG2));
    out_free = !out_valid || out_ready;
  end

  // RAM and divider control.
  always_comb begin
    sc_we     = 1'b0;
    sc_waddr  = s;
    sum_wd    = '0;
    cnt_wd    = '0;
    sc_raddr  = (state == ST_IDLE) ? AW'(head.slice) : s;
    mean_we   = 1'b0;
    mean_wd   = '0;
    fact_we   = 1'b0;
    fact_wd   = sid_pkg::ONE_Q16;
    div_start = 1'b0;
    div_num   = sid_pkg::DIVN_W'(sum_mag);
    div_den   = sid_pkg::DIVD_W'(cnt_rd);
    case (state)
      ST_CLEAR: begin
        sc_we    = 1'b1;
        sc_waddr = clr_idx;
      end
      ST_MEAS: begin
        sc_waddr = AW'(cur.slice);
        sc_we    = meas_upd;
        sum_wd   = sid_pkg::SUM_W'(sum_rd + sid_pkg::SUM_W'(cur.sample));
        cnt_wd   = cnt_rd + 1'b1;
      end
      ST_W1_LD: begin
        sc_we     = 1'b1;
        mean_we   = (cnt_rd == '0);
        div_start = (cnt_rd != '0);
      end
      ST_W1_DIV: begin
        mean_we = div_done;
        mean_wd = neg ? SW'(-div_q[SW-1:0]) : div_q[SW-1:0];
      end
      ST_S_DEN: begin
        fact_we = (wsum == '0) || (mean_c == '0);
      end
      ST_S_DLD: begin
        div_start = 1'b1;
        div_num   = {acc_mag, 16'b0};
        div_den   = den_mag[sid_pkg::DIVD_W-1:0];
      end
      ST_S_DIV: begin
        fact_we = div_done;
        fact_wd = fact_div;
      end
      default: begin
      end
    endcase
  end

  assign pop      = (state == ST_IDLE) && head_valid;
  assign clearing = (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_CSAT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_idx == AW'(MAX_SLICES - 1)) begin
            clr_idx <= '0;
            state   <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (head_valid) begin
            cur   <= head;
            state <= head.req_type ? ST_CMUL : ST_MEAS;
          end
        end
        ST_MEAS: begin
          s <= '0;
          if (cur.last) begin
            // With no slice in use the walk reduces to clearing the sums.
            state <= (n_eff != '0) ? ST_W1_ISS : ST_CLEAR;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CMUL: begin
          cprod <= cur.sample * fact_rd;
          state <= ST_CSAT;
        end
        ST_CSAT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_sample  <= (cur.present && cur.in_use) ? sat_val : cur.sample;
            out_present <= cur.present;
            out_last    <= cur.last;
            state       <= ST_IDLE;
          end
        end
        ST_W1_ISS: begin
          state <= ST_W1_LD;
        end
        ST_W1_LD, ST_W1_DIV: begin
          if (state == ST_W1_LD) begin
            neg <= sum_rd[sid_pkg::SUM_W-1];
          end
          if ((state == ST_W1_LD && cnt_rd != '0) ||
              (state == ST_W1_DIV && !div_done)) begin
            state <= ST_W1_DIV;
          end else if (last_slice) begin
            s      <= '0;
            tap_o  <= '0;
            tap_hi <= 1'b1;
            acc    <= '0;
            wsum   <= '0;
            state  <= ST_S_ISS;
          end else begin
            s     <= s + 1'b1;
            state <= ST_W1_ISS;
          end
        end
        ST_S_ISS: begin
          if (nb_ok) begin
            state <= ST_S_MUL;
          end else if (last_tap) begin
            state <= ST_S_DEN;
          end else begin
            tap_o  <= tap_hi ? tap_o + 1'b1 : tap_o;
            tap_hi <= !tap_hi;
          end
        end
        ST_S_MUL: begin
          sprod <= $signed({1'b0, tap_w}) * mean_rd;
          wsum  <= wsum + sid_pkg::WSUM_W'(tap_w);
          if (tap_o == '0) begin
            mean_c <= mean_rd;
          end
          state <= ST_S_ACC;
        end
        ST_S_ACC: begin
          acc <= acc + sid_pkg::ACC_W'(sprod);
          if (last_tap) begin
            state <= ST_S_DEN;
          end else begin
            tap_o  <= tap_hi ? tap_o + 1'b1 : tap_o;
            tap_hi <= !tap_hi;
            state  <= ST_S_ISS;
          end
        end
        ST_S_DEN, ST_S_DLD, ST_S_DIV: begin
          if (state == ST_S_DEN && !fact_we) begin
            den   <= $signed({1'b0, wsum}) * mean_c;
            state <= ST_S_DLD;
          end else if (state == ST_S_DLD) begin
            neg   <= acc[sid_pkg::ACC_W-1] ^ den[sid_pkg::DEN_W-1];
            state <= ST_S_DIV;
          end else if (state == ST_S_DIV && !div_done) begin
            state <= ST_S_DIV;
          end else if (last_slice) begin
            // Slices outside the walked range are cleared as well.
            state <= ST_CLEAR;
          end else begin
            s      <= s + 1'b1;
            tap_o  <= '0;
            tap_hi <= 1'b1;
            acc    <= '0;
            wsum   <= '0;
            state  <= ST_S_ISS;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  sid_ram #(.WIDTH(sid_pkg::SUM_W), .DEPTH(MAX_SLICES)) u_sum (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sum_wd),
    .raddr(sc_raddr), .rdata(sum_rd)
  );

  sid_ram #(.WIDTH(sid_pkg::CNT_W), .DEPTH(MAX_SLICES)) u_cnt (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(cnt_wd),
    .raddr(sc_raddr), .rdata(cnt_rd)
  );

  sid_ram #(.WIDTH(SW), .DEPTH(MAX_SLICES)) u_mean (
    .clk(clk), .we(mean_we), .waddr(s), .wdata(mean_wd),
    .raddr(mean_raddr), .rdata(mean_rd)
  );

  sid_ram #(.WIDTH(sid_pkg::FACT_W), .DEPTH(MAX_SLICES)) u_fact (
    .clk(clk), .we(fact_we), .waddr(s), .wdata(fact_wd),
    .raddr(AW'(head.slice)), .rdata(fact_rd)
  );

  sid_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q), .ovf(div_ovf)
  );

endmodule

// ===== rtl/slice_intensity_destriper.sv =====
// Top level of the slice intensity destriper: configuration registers,
// input queue and processing back end. Depends on sid_pkg, sid_front, sid_back.
//
// Usage. Voxel words enter on s_axis; tdata carries slice_index and sample,
// tuser carries req_type and present, tlast marks the end of a pass.
// Corrected voxels of the correct pass leave on m_axis; measure words give
// no output. The cfg channel writes slices_in_use (index 0) and the seven
// kernel taps (indexes 1 to 7); it is always ready.
// In the back end a measure word goes through a read-modify-write of the
// per-slice memories and a correct word through a registered multiply
// ahead of saturation; each word is finished before the next leaves the
// queue. A correct word is registered onto m_axis after saturation.
// The last measure word starts a walk over the slices in use that forms
// means (serial divider, one bit a cycle) and then smooths and forms
// factors, followed by a pass over all MAX_SLICES entries that clears the
// accumulators; input is held off meanwhile once the four-word
// queue fills, and s_axis_tready is low during the clearing pass.
// Reset clears the accumulators in a pass over all MAX_SLICES entries during which
// s_axis_tready is low. A stalled m_axis holds its word; the queue keeps
// taking input until it is full.
module slice_intensity_destriper #(
  parameter int MAX_SLICES = sid_pkg::MAX_SLICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // slice_index, sample
  input  logic [1:0]                        s_axis_tuser,  // req_type, present
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // corrected_sample
  output logic                              m_axis_tuser,  // out_present
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sid_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sid_pkg::cfg_t   cfg;
  sid_pkg::item_t  head;
  logic            head_valid;
  logic            pop;
  logic            clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slices_in_use <= sid_pkg::SLICES_RST;
      cfg.taps          <= {{((sid_pkg::HALF_TAPS - 1) * sid_pkg::TAP_W){1'b0}},
                            sid_pkg::TAP_C_RST};
    end else if (cfg_valid) begin
      case (cfg_index)
        sid_pkg::CFG_SLICES: begin
          cfg.slices_in_use <= cfg_data[sid_pkg::NUSE_W-1:0];
        end
        default: begin
          cfg.taps[cfg_index - sid_pkg::CFG_TAP_FIRST] <= cfg_data;
        end
      endcase
    end
  end

  sid_front #(.MAX_SLICES(MAX_SLICES)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .slices_in_use(cfg.slices_in_use), .clearing(clearing), .pop(pop),
    .head(head), .head_valid(head_valid)
  );

  sid_back #(.MAX_SLICES(MAX_SLICES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .head_valid(head_valid),
    .pop(pop), .clearing(clearing),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_sample(m_axis_tdata), .out_present(m_axis_tuser),
    .out_last(m_axis_tlast)
  );

endmodule

// ===== rtl/sid_checker.sv =====
// Port-level checks of the slice intensity destriper, bound to the top level.
// Depends on slice_intensity_destriper.
module sid_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [15:0]                     m_axis_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // The output word holds while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed under stall");

  // The accumulator clearing pass keeps input closed right after reset.
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input open during clearing pass");

  // No output word appears right after reset.
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output word right after reset");

  // Configuration writes are never back-pressured.
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind slice_intensity_destriper sid_checker u_sid_checker (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
